[rtl/sha1b_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared types and constants: queued item, sequencer states, SHA-1 constants.
// ----------------------------------------------------------------------------
package sha1b_pkg;

   // One queued input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_EMIT
   } state_type;

   // Chain initial values
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hc3d2e1f0;

   // Round constants
   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   // Padding marker byte and block geometry
   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] BLOCK_LAST = 6'd63;

   // Round counter limits
   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [6:0] ROUND_B1   = 7'd20;
   localparam logic [6:0] ROUND_B2   = 7'd40;
   localparam logic [6:0] ROUND_B3   = 7'd60;

endpackage

[rtl/sha1b_if.sv]
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher channels
// Valid/ready channels for message bytes and for digest results.
// ----------------------------------------------------------------------------
interface sha1b_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input end_of_message, output ready);
endinterface

interface sha1b_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word0;
   logic [31:0] digest_word1;
   logic [31:0] digest_word2;
   logic [31:0] digest_word3;
   logic [31:0] digest_word4;

   modport source (output valid, output digest_word0, output digest_word1,
                   output digest_word2, output digest_word3,
                   output digest_word4, input ready);
   modport sink   (input valid, input digest_word0, input digest_word1,
                   input digest_word2, input digest_word3,
                   input digest_word4, output ready);
endinterface

[rtl/sha1b_front.sv]
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts input items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module sha1b_front
   import sha1b_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   sha1b_req_if.sink       req_chan,
   output logic            item_valid,
   output item_type        item,
   input  logic            item_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           queue_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;
   item_type           new_item;

   // Handshakes on both sides
   assign req_chan.ready = (count_ff != CNT_W'(DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (count_ff != '0);
   assign pop            = item_valid && item_ready;
   assign item           = queue_ff[rd_ptr_ff];

   // Pack the transfer into a queue entry
   always_comb begin
      new_item.data_byte      = req_chan.data_byte;
      new_item.byte_present   = req_chan.byte_present;
      new_item.end_of_message = req_chan.end_of_message;
   end

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue did not shrink on pop");
`endif

endmodule

[rtl/sha1b_core.sv]
// ----------------------------------------------------------------------------
// SHA-1 back end
// Packs bytes into the block window, pads, runs 80 rounds, emits the digest.
// ----------------------------------------------------------------------------
module sha1b_core
   import sha1b_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  item_type        item,
   output logic            item_ready,
   sha1b_rsp_if.source     rsp_chan
);

   state_type     state_ff, state_in;
   logic [5:0]    fill_ff, fill_in;
   logic [63:0]   bits_ff, bits_in;
   logic [6:0]    round_ff, round_in;
   logic          padding_ff, padding_in;
   logic          marker_ff, marker_in;
   logic          len_ok_ff, len_ok_in;
   logic          final_ff, final_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   chain_ff [5];
   logic [31:0]   chain_in [5];
   logic [31:0]   work_ff [5];
   logic [31:0]   work_in [5];
   logic [31:0]   window_ff [16];
   logic [31:0]   window_in [16];
   logic [31:0]   digest_ff [5];
   logic [31:0]   digest_in [5];

   logic          shift_en;
   logic [7:0]    shift_byte;
   logic          load_work;
   logic          rsp_load;
   logic [7:0]    len_byte;
   logic [31:0]   f_val;
   logic [31:0]   k_val;
   logic [31:0]   temp;
   logic [31:0]   sched_next;

   // Length byte for the current fill position, most significant first
   assign len_byte = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];

   // Round function and constant
   always_comb begin
      priority if (round_ff < ROUND_B1) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = K0;
      end else if (round_ff < ROUND_B2) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K1;
      end else if (round_ff < ROUND_B3) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                 (work_ff[2] & work_ff[3]);
         k_val = K2;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K3;
      end
   end

   assign temp = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4] +
                 k_val + window_ff[0];

   // Next schedule word, sixteen ahead of the word in use
   always_comb begin
      logic [31:0] x;
      x = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];
      sched_next = {x[30:0], x[31]};
   end

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      round_in   = round_ff;
      padding_in = padding_ff;
      marker_in  = marker_ff;
      len_ok_in  = len_ok_ff;
      final_in   = final_ff;
      chain_in   = chain_ff;
      item_ready = 1'b0;
      shift_en   = 1'b0;
      shift_byte = '0;
      load_work  = 1'b0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_ready = 1'b1;
               if (item.byte_present) begin
                  shift_en   = 1'b1;
                  shift_byte = item.data_byte;
                  bits_in    = bits_ff + 64'd8;
                  fill_in    = fill_ff + 1'b1;
               end
               if (item.end_of_message) begin
                  padding_in = 1'b1;
                  marker_in  = 1'b0;
                  len_ok_in  = 1'b0;
                  final_in   = 1'b0;
               end
               if (item.byte_present && fill_ff == BLOCK_LAST) begin
                  load_work = 1'b1;
                  round_in  = '0;
                  state_in  = ST_ROUND;
               end else if (item.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end

         ST_PAD: begin
            shift_en = 1'b1;
            fill_in  = fill_ff + 1'b1;
            if (!marker_ff) begin
               shift_byte = PAD_MARK;
               marker_in  = 1'b1;
               if (fill_ff < LEN_POS) begin
                  len_ok_in = 1'b1;
               end
            end else if (len_ok_ff && fill_ff >= LEN_POS) begin
               shift_byte = len_byte;
               if (fill_ff == BLOCK_LAST) begin
                  final_in = 1'b1;
               end
            end
            if (fill_ff == BLOCK_LAST) begin
               load_work = 1'b1;
               round_in  = '0;
               state_in  = ST_ROUND;
            end
         end

         ST_ROUND: begin
            round_in = round_ff + 1'b1;
            if (round_ff == ROUND_LAST) begin
               // Fold the last round straight into the chain
               chain_in[0] = chain_ff[0] + temp;
               chain_in[1] = chain_ff[1] + work_ff[0];
               chain_in[2] = chain_ff[2] + {work_ff[1][1:0], work_ff[1][31:2]};
               chain_in[3] = chain_ff[3] + work_ff[2];
               chain_in[4] = chain_ff[4] + work_ff[3];
               round_in    = '0;
               len_ok_in   = len_ok_ff | marker_ff;
               if (final_ff) begin
                  state_in = ST_EMIT;
               end else if (padding_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load   = 1'b1;
               chain_in   = '{IV0, IV1, IV2, IV3, IV4};
               bits_in    = '0;
               padding_in = 1'b0;
               marker_in  = 1'b0;
               len_ok_in  = 1'b0;
               final_in   = 1'b0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Block window: byte shift while filling, schedule shift while hashing
   always_comb begin
      window_in = window_ff;
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            window_in[i] = {window_ff[i][23:0], window_ff[i+1][31:24]};
         end
         window_in[15] = {window_ff[15][23:0], shift_byte};
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[15] = sched_next;
      end
   end

   // Working words a..e
   always_comb begin
      work_in = work_ff;
      if (load_work) begin
         work_in = chain_ff;
      end else if (state_ff == ST_ROUND) begin
         work_in[0] = temp;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
   end

   // Output register
   always_comb begin
      digest_in = rsp_load ? chain_ff : digest_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.digest_word0 = digest_ff[0];
   assign rsp_chan.digest_word1 = digest_ff[1];
   assign rsp_chan.digest_word2 = digest_ff[2];
   assign rsp_chan.digest_word3 = digest_ff[3];
   assign rsp_chan.digest_word4 = digest_ff[4];

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         round_ff     <= '0;
         padding_ff   <= 1'b0;
         marker_ff    <= 1'b0;
         len_ok_ff    <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '{IV0, IV1, IV2, IV3, IV4};
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         round_ff     <= round_in;
         padding_ff   <= padding_in;
         marker_ff    <= marker_in;
         len_ok_ff    <= len_ok_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      window_ff <= window_in;
      work_ff   <= work_in;
      digest_ff <= digest_in;
   end

`ifndef SYNTHESIS
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      round_ff <= ROUND_LAST)
      else $error("round counter out of range");

   a_pad_in_message: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> padding_ff)
      else $error("padding without a finished message");

   a_final_has_length: assert property (@(posedge clock) disable iff (reset)
      final_ff |-> (padding_ff && marker_ff && len_ok_ff))
      else $error("final block without marker and length");
`endif

endmodule

[rtl/sha1_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Top level: input queue in front of the block/round engine.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per transfer: data_byte, byte_present and
//   end_of_message. A byte is appended when byte_present is set; an item
//   with end_of_message pads and finishes the message after its byte.
//   rsp_chan returns one transfer per finished message with digest_word0
//   through digest_word4 (H0..H4, most significant byte first).
// Timing:
//   The engine takes one byte per cycle from the queue while it is idle
//   and runs one SHA-1 round per cycle, 80 rounds on each full 64-byte
//   block, taking no bytes meanwhile. On finish it writes padding one byte
//   per cycle up to the end of the block (plus one more block when fewer
//   than nine bytes remain), runs 80 rounds per padded block, then loads
//   the digest into the output register in ST_EMIT once that register is
//   free.
// Reset:
//   Synchronous, active high; the queue empties and the chain returns to
//   the SHA-1 initial values.
// Stalls:
//   The digest waits in an output register; while it is not taken, the
//   next digest holds in the engine and the queue keeps taking items until
//   full (QUEUE_DEPTH entries).
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher
   import sha1b_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   sha1b_req_if.sink    req_chan,
   sha1b_rsp_if.source  rsp_chan
);

   logic      item_valid;
   logic      item_ready;
   item_type  item;

   sha1b_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   sha1b_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

[tb/sha1_byte_stream_hasher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Feeds messages one byte per transfer with random gaps and stalls on both
// channels. A directed table is followed by random messages whose lengths
// favor the padding boundaries. Every digest is checked word by word against
// an in-bench SHA-1 model or, for well-known messages, a typed-in digest.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_tb;
   import sha1b_pkg::*;

   // Five digest words, H0 first
   typedef struct packed {
      logic [31:0] h0;
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] h3;
      logic [31:0] h4;
   } digest_type;

   // One row of the directed table; known marks a typed-in digest
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
      logic       known;
      digest_type digest;
   } stim_row_type;

   localparam int         RANDOM_ITEMS = 1650;
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES = 300;
   localparam int         REPORT_LIMIT = 10;
   localparam int         NUM_ROWS     = 15;
   localparam int         NUM_LENS     = 14;
   localparam digest_type NO_DIGEST    = '0;
   localparam digest_type EMPTY_DIGEST = {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                          32'h95601890, 32'hafd80709};
   localparam digest_type ABC_DIGEST   = {32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                          32'h7850c26c, 32'h9cd0d89d};

   logic clock;
   logic reset;

   sha1b_req_if req_chan ();
   sha1b_rsp_if rsp_chan ();

   sha1_byte_stream_hasher dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Directed table: empty message, ignored byte on finish, "abc", extremes
   stim_row_type directed_rows [NUM_ROWS] = '{
      {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      {8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      {8'h3c, 1'b0, 1'b0, 1'b0, NO_DIGEST},
      {8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      {8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      {8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
      {8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      {8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      {8'h5a, 1'b0, 1'b0, 1'b0, NO_DIGEST},
      {8'ha5, 1'b0, 1'b1, 1'b0, NO_DIGEST},
      {8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
      {8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
      {8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      {8'h7f, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      {8'h01, 1'b0, 1'b1, 1'b0, NO_DIGEST}
   };

   // Message lengths around the padding and block boundaries
   int boundary_lens [NUM_LENS] = '{0, 1, 54, 55, 56, 57, 62, 63, 64, 65,
                                    119, 120, 127, 128};

   // Model state
   logic [7:0]  blk_buf [64];
   int unsigned blk_fill;
   logic [63:0] msg_bit_len;
   logic [31:0] chain [5];

   digest_type  pending_digests [$];
   digest_type  oldest_digest;
   int          mismatch_count;
   int          idle_cycles;
   bit          burst_mode;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run the 80 rounds over the current block and fold into the chain
   function automatic void sha1_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++)
         w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
         if (r >= 16) begin
            x = w[(r+13) & 15] ^ w[(r+8) & 15] ^ w[(r+2) & 15] ^ w[r & 15];
            w[r & 15] = {x[30:0], x[31]};
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   // Restart the chain for a new message
   function automatic void sha1_restart();
      blk_fill    = 0;
      msg_bit_len = '0;
      chain[0]    = IV0;
      chain[1]    = IV1;
      chain[2]    = IV2;
      chain[3]    = IV3;
      chain[4]    = IV4;
   endfunction

   // Absorb one transfer; on finish, pad and return the digest
   function automatic bit sha1_absorb(input item_type it, output digest_type dig);
      int unsigned idx;
      dig = NO_DIGEST;
      if (it.byte_present) begin
         blk_buf[blk_fill] = it.data_byte;
         blk_fill++;
         msg_bit_len += 64'd8;
         if (blk_fill == 64) begin
            sha1_compress();
            blk_fill = 0;
         end
      end
      if (!it.end_of_message)
         return 1'b0;
      blk_buf[blk_fill] = PAD_MARK;
      idx = blk_fill + 1;
      // spill into an extra block when the length does not fit
      if (idx > LEN_POS) begin
         while (idx < 64) begin
            blk_buf[idx] = 8'h00;
            idx++;
         end
         sha1_compress();
         idx = 0;
      end
      while (idx < LEN_POS) begin
         blk_buf[idx] = 8'h00;
         idx++;
      end
      for (int j = 0; j < 8; j++)
         blk_buf[LEN_POS + j] = msg_bit_len[63 - 8*j -: 8];
      sha1_compress();
      dig = {chain[0], chain[1], chain[2], chain[3], chain[4]};
      sha1_restart();
      return 1'b1;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   function automatic void check_word(input int idx, input logic [31:0] expv,
                                      input logic [31:0] actv);
      if (actv !== expv)
         note_mismatch($sformatf("digest_word%0d expected %08h got %08h",
                                 idx, expv, actv));
   endfunction

   // Wait before a transfer: none in burst stretches, else a random wait
   function automatic int draw_wait();
      if (burst_mode)
         return 0;
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
   endfunction

   // Drive one item, hold until transferred, then advance the model
   task automatic send_item(input item_type it, input bit use_typed,
                            input digest_type typed);
      int         gap;
      digest_type dig;
      gap = draw_wait();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.data_byte      <= it.data_byte;
      req_chan.byte_present   <= it.byte_present;
      req_chan.end_of_message <= it.end_of_message;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (sha1_absorb(it, dig))
         pending_digests.insert(pending_digests.size(), use_typed ? typed : dig);
   endtask

   // Result side: stall a random number of cycles before each transfer
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Check each digest transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_digests.size() == 0) begin
            note_mismatch("digest transfer with none outstanding");
         end else begin
            oldest_digest = pending_digests.pop_front();
            check_word(0, oldest_digest.h0, rsp_chan.digest_word0);
            check_word(1, oldest_digest.h1, rsp_chan.digest_word1);
            check_word(2, oldest_digest.h2, rsp_chan.digest_word2);
            check_word(3, oldest_digest.h3, rsp_chan.digest_word3);
            check_word(4, oldest_digest.h4, rsp_chan.digest_word4);
         end
      end
   end

   // Watchdog: end the run after too long without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      item_type it;
      int       len;
      int       items_sent;
      bit       tail_finish;
      burst_mode              = 1'b0;
      items_sent              = 0;
      sha1_restart();
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.data_byte      <= 8'h00;
      req_chan.byte_present   <= 1'b0;
      req_chan.end_of_message <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int n = 0; n < NUM_ROWS; n++) begin
         it.data_byte      = directed_rows[n].data_byte;
         it.byte_present   = directed_rows[n].byte_present;
         it.end_of_message = directed_rows[n].end_of_message;
         send_item(it, directed_rows[n].known, directed_rows[n].digest);
      end

      // Random messages, lengths biased toward the block boundaries
      while (items_sent < RANDOM_ITEMS) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 4) == 0)
            len = boundary_lens[$urandom_range(0, NUM_LENS - 1)];
         else
            len = $urandom_range(0, 24);
         tail_finish = (len > 0) && ($urandom_range(0, 1) == 1);
         for (int n = 0; n < len; n++) begin
            // drop in an occasional item that carries nothing
            if ($urandom_range(0, 11) == 0) begin
               it.data_byte      = 8'($urandom_range(0, 255));
               it.byte_present   = 1'b0;
               it.end_of_message = 1'b0;
               send_item(it, 1'b0, NO_DIGEST);
               items_sent++;
            end
            it.data_byte      = 8'($urandom_range(0, 255));
            it.byte_present   = 1'b1;
            it.end_of_message = tail_finish && (n == len - 1);
            send_item(it, 1'b0, NO_DIGEST);
            items_sent++;
         end
         if (!tail_finish) begin
            it.data_byte      = 8'($urandom_range(0, 255));
            it.byte_present   = 1'b0;
            it.end_of_message = 1'b1;
            send_item(it, 1'b0, NO_DIGEST);
            items_sent++;
         end
      end
      req_chan.valid <= 1'b0;

      // Drain outstanding digests, then hold for stray transfers
      while (pending_digests.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_digests.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
